// File: rtl/core/lkvc_pkg.sv
package lkvc_pkg;

    localparam int KEY_W      = 32;
    localparam int VAL_W      = 32;
    localparam int LIMIT_W    = 5;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [LIMIT_W-1:0] ENTRY_LIMIT_RESET = 5'd16;
    localparam logic               REG_ENTRY_LIMIT   = 1'b0;

    typedef enum logic [1:0] {
        OP_LOOKUP     = 2'd0,
        OP_STORE      = 2'd1,
        OP_INVALIDATE = 2'd2
    } t_op;

    typedef struct packed {
        logic [1:0]       operation;
        logic [KEY_W-1:0] lookup_key;
        logic [VAL_W-1:0] store_value;
    } t_in_item;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
        logic [VAL_W-1:0] evicted_value;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic store;
        logic clear;
        logic ignore;
    } t_dp_cmd;

endpackage

// File: rtl/core/lkvc_ctrl.sv
module lkvc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [1:0]         i_op,
    output logic               o_busy,
    output logic               o_done,
    output lkvc_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_LOOKUP = 5'b00010,
        ST_STORE  = 5'b00100,
        ST_CLEAR  = 5'b01000,
        ST_IGNORE = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   capture;

    assign capture = (r_state == ST_IDLE) && i_start;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    case (lkvc_pkg::t_op'(i_op))
                        lkvc_pkg::OP_LOOKUP:     n_state = ST_LOOKUP;
                        lkvc_pkg::OP_STORE:      n_state = ST_STORE;
                        lkvc_pkg::OP_INVALIDATE: n_state = ST_CLEAR;
                        default:                 n_state = ST_IGNORE;
                    endcase
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy        = (r_state != ST_IDLE);
    assign o_done        = (r_state != ST_IDLE);
    assign o_cmd.capture = capture;
    assign o_cmd.lookup  = (r_state == ST_LOOKUP);
    assign o_cmd.store   = (r_state == ST_STORE);
    assign o_cmd.clear   = (r_state == ST_CLEAR);
    assign o_cmd.ignore  = (r_state == ST_IGNORE);

`ifndef NO_ASSERTIONS
    a_capture_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        capture |=> o_done)
        else $error("transaction accepted without a result next cycle");
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");
    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $onehot({o_cmd.lookup, o_cmd.store, o_cmd.clear, o_cmd.ignore}))
        else $error("datapath given more than one action");
`endif

endmodule

// File: rtl/core/lkvc_datapath.sv
module lkvc_datapath #(
    parameter int DEPTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  lkvc_pkg::t_dp_cmd                  i_cmd,
    input  lkvc_pkg::t_in_item                 i_item,
    input  logic [lkvc_pkg::LIMIT_W-1:0]       i_entry_limit,
    output lkvc_pkg::t_out_item                o_result
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > lkvc_pkg::LIMIT_W) ? CW : lkvc_pkg::LIMIT_W;

    logic [lkvc_pkg::KEY_W-1:0] r_keys [DEPTH];
    logic [lkvc_pkg::VAL_W-1:0] r_mem  [DEPTH];
    logic [DEPTH-1:0]           r_valid, n_valid;
    logic [IW-1:0]              r_rank [DEPTH];
    logic [IW-1:0]              n_rank [DEPTH];
    logic [CW-1:0]              r_count, n_count;

    logic [lkvc_pkg::KEY_W-1:0] r_key;
    logic [lkvc_pkg::VAL_W-1:0] r_value;
    logic [lkvc_pkg::VAL_W-1:0] r_rd_data;
    logic                       r_hit, r_evict;
    logic [DEPTH-1:0]           r_hit_oh, r_victim_oh, r_slot_oh;
    logic [IW-1:0]              r_hit_idx, r_slot_idx, r_hit_rank;

    logic [DEPTH-1:0]           match, victim_oh, free, slot_oh;
    logic                       hit, need_evict;
    logic [IW-1:0]              hit_idx, victim_idx, slot_idx, hit_rank, last_rank, rd_addr;
    logic [LW-1:0]              limit_ext;
    logic [CW-1:0]              eff_limit, count_m1;
    logic                       wr_en;
    logic [IW-1:0]              wr_addr;

    // lookup side, evaluated on the accepted transaction
    always_comb begin
        limit_ext = LW'(i_entry_limit);
        if (limit_ext == '0 || limit_ext > LW'(DEPTH)) begin
            eff_limit = CW'(DEPTH);
        end else begin
            eff_limit = limit_ext[CW-1:0];
        end
        count_m1   = r_count - CW'(1);
        last_rank  = count_m1[IW-1:0];
        need_evict = (r_count >= eff_limit) && (r_count != '0);
        hit_idx    = '0;
        hit_rank   = '0;
        victim_idx = '0;
        slot_idx   = '0;
        for (int i = 0; i < DEPTH; i++) begin
            match[i]     = r_valid[i] && (r_keys[i] == i_item.lookup_key);
            victim_oh[i] = need_evict && r_valid[i] && (r_rank[i] == last_rank);
        end
        hit     = |match;
        free    = ~(r_valid & ~victim_oh);
        slot_oh = free & (~free + DEPTH'(1));
        for (int i = 0; i < DEPTH; i++) begin
            if (match[i]) begin
                hit_idx  = hit_idx | IW'(i);
                hit_rank = hit_rank | r_rank[i];
            end
            if (victim_oh[i]) begin
                victim_idx = victim_idx | IW'(i);
            end
            if (slot_oh[i]) begin
                slot_idx = slot_idx | IW'(i);
            end
        end
        rd_addr = hit ? hit_idx : victim_idx;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_key       <= i_item.lookup_key;
            r_value     <= i_item.store_value;
            r_hit       <= hit;
            r_hit_oh    <= match;
            r_hit_idx   <= hit_idx;
            r_hit_rank  <= hit_rank;
            r_evict     <= |victim_oh;
            r_victim_oh <= victim_oh;
            r_slot_oh   <= slot_oh;
            r_slot_idx  <= slot_idx;
        end
    end

    // value store
    assign wr_en   = i_cmd.store;
    assign wr_addr = r_hit ? r_hit_idx : r_slot_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (wr_en) begin
            r_mem[wr_addr] <= r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (i_cmd.store && !r_hit && r_slot_oh[i]) begin
                r_keys[i] <= r_key;
            end
        end
    end

    // recency update
    always_comb begin
        n_valid = r_valid;
        n_count = r_count;
        for (int i = 0; i < DEPTH; i++) begin
            n_rank[i] = r_rank[i];
        end
        if ((i_cmd.lookup || i_cmd.store) && r_hit) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (r_hit_oh[i]) begin
                    n_rank[i] = '0;
                end else if (r_valid[i] && r_rank[i] < r_hit_rank) begin
                    n_rank[i] = r_rank[i] + IW'(1);
                end
            end
        end else if (i_cmd.store) begin
            n_valid = (r_valid & ~r_victim_oh) | r_slot_oh;
            n_count = r_evict ? r_count : r_count + CW'(1);
            for (int i = 0; i < DEPTH; i++) begin
                if (r_slot_oh[i]) begin
                    n_rank[i] = '0;
                end else if (r_valid[i] && !r_victim_oh[i]) begin
                    n_rank[i] = r_rank[i] + IW'(1);
                end
            end
        end else if (i_cmd.clear) begin
            n_valid = '0;
            n_count = '0;
            for (int i = 0; i < DEPTH; i++) begin
                n_rank[i] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            for (int i = 0; i < DEPTH; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            r_valid <= n_valid;
            r_count <= n_count;
            for (int i = 0; i < DEPTH; i++) begin
                r_rank[i] <= n_rank[i];
            end
        end
    end

    always_comb begin
        o_result.hit           = i_cmd.lookup && r_hit;
        o_result.read_value    = (i_cmd.lookup && r_hit) ? r_rd_data : '0;
        o_result.evicted       = i_cmd.store && !r_hit && r_evict;
        o_result.evicted_value = (i_cmd.store && !r_hit && r_evict) ? r_rd_data : '0;
    end

`ifndef NO_ASSERTIONS
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_count))
        else $error("entry count disagrees with valid entries");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");
    a_victim_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.capture |-> $onehot0(victim_oh) && $onehot0(match))
        else $error("ambiguous victim or duplicate key");
`endif

endmodule

// File: rtl/core/lru_key_value_cache_unit.sv
// LRU key/value cache, fully associative, up to DEPTH entries.
// Input: start/busy command channel carrying operation, lookup_key and
//   store_value; a transaction is taken on a clock edge with start high and
//   busy low.
// Output: one result per transaction on o_result, marked by o_done for
//   exactly one cycle; it cannot be held off, so capture it when o_done is high.
//   hit/read_value answer a lookup, evicted/evicted_value report the least
//   recent entry released by a store of a new key into a cache at its entry limit.
// Timing: keys are compared against all entries in parallel in the accept
//   cycle and the value store is read there; o_done follows in the next cycle
//   while recency, keys and values are written back. busy is high for that
//   one cycle, so a new transaction is not taken until o_done has been given.
// Config: APB register entry_limit at address 0 (5 bits, 0 or above DEPTH
//   means DEPTH); write it only while idle. pready is tied high.
// Reset: synchronous, active low; all entries invalid, entry_limit = 16.
//   Invalidate drops all entries in one transaction and reports nothing.
module lru_key_value_cache_unit #(
    parameter int DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  lkvc_pkg::t_in_item                  i_item,
    output logic                                o_done,
    output lkvc_pkg::t_out_item                 o_result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lkvc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lkvc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lkvc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    logic [lkvc_pkg::LIMIT_W-1:0] r_entry_limit;
    logic                         limit_sel;
    lkvc_pkg::t_dp_cmd            cmd;

    assign pready    = 1'b1;
    assign limit_sel = (paddr[lkvc_pkg::APB_ADDR_W-1] == lkvc_pkg::REG_ENTRY_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_limit <= lkvc_pkg::ENTRY_LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && limit_sel) begin
            r_entry_limit <= pwdata[lkvc_pkg::LIMIT_W-1:0];
        end
    end

    assign prdata = limit_sel ? lkvc_pkg::APB_DATA_W'(r_entry_limit) : '0;

    lkvc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_item.operation),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    lkvc_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_item        (i_item),
        .i_entry_limit (r_entry_limit),
        .o_result      (o_result)
    );

endmodule
